// ----- src/masked_grayscale_invert_blend_defines.svh -----
// Assertion macros shared by the blend pipeline.
`ifndef MASKED_GRAYSCALE_INVERT_BLEND_DEFINES_SVH
`define MASKED_GRAYSCALE_INVERT_BLEND_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MGIB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mgib same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MGIB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mgib next-cycle check failed");

`endif

// ----- src/mgib_pkg.sv -----
package mgib_pkg;

    localparam int unsigned NumCh  = 4;

    localparam logic [7:0] LumaWr    = 8'd54;
    localparam logic [7:0] LumaWg    = 8'd183;
    localparam logic [7:0] LumaWb    = 8'd19;
    localparam logic [7:0] LumaRound = 8'd128;
    localparam logic [7:0] MixRound  = 8'd127;
    localparam logic [7:0] FullMix   = 8'd255;

    typedef enum logic [1:0] {
        REG_FILTER_MODE = 2'd0,
        REG_USE_MASK    = 2'd1,
        REG_STRENGTH    = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    typedef enum logic {
        MODE_GRAY   = 1'b0,
        MODE_INVERT = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode      filter_mode;
        logic       use_mask;
        logic [7:0] strength;
    } t_cfg;

    // Exact x/255 for x below 65280.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ----- src/mgib_ifs.sv -----
interface mgib_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_pixel;
    logic [31:0] current_pixel;
    logic [7:0]  mask_level;
    modport source (output valid, source_pixel, current_pixel, mask_level, input ready);
    modport sink (input valid, source_pixel, current_pixel, mask_level, output ready);
endinterface

interface mgib_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_pixel;
    modport source (output valid, result_pixel, input ready);
    modport sink (input valid, result_pixel, output ready);
endinterface

interface mgib_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/mgib_cfg_regs.sv -----
module mgib_cfg_regs
    import mgib_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mgib_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_mode <= MODE_GRAY;
            r_cfg.use_mask    <= 1'b0;
            r_cfg.strength    <= FullMix;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_FILTER_MODE: r_cfg.filter_mode <= t_mode'(i_cfg.data[0]);
                REG_USE_MASK:    r_cfg.use_mask    <= i_cfg.data[0];
                REG_STRENGTH:    r_cfg.strength    <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ----- src/mgib_effect.sv -----
module mgib_effect
    import mgib_pkg::*;
(
    input  t_mode       i_mode,
    input  logic [31:0] i_src,
    output logic [31:0] o_eff
);

    logic [7:0]  a, r, g, b, luma, gray;
    logic [15:0] sum;
    logic [7:0]  inv [3];

    assign a = i_src[31:24];
    assign r = i_src[23:16];
    assign g = i_src[15:8];
    assign b = i_src[7:0];

    always_comb begin
        sum  = 16'(r * LumaWr) + 16'(g * LumaWg) + 16'(b * LumaWb) + {8'd0, LumaRound};
        luma = sum[15:8];
        gray = (luma > a) ? a : luma;
        for (int i = 0; i < 3; i++) begin
            // Colour above alpha saturates to zero.
            inv[i] = (a > i_src[i*8 +: 8]) ? (a - i_src[i*8 +: 8]) : 8'd0;
        end
        case (i_mode)
            MODE_INVERT: o_eff = {a, inv[2], inv[1], inv[0]};
            MODE_GRAY:   o_eff = {a, gray, gray, gray};
            default:     o_eff = {a, gray, gray, gray};
        endcase
    end

endmodule

// ----- src/masked_grayscale_invert_blend.sv -----
// Results leave on the output from the last of four pipeline registers; the
// first of the four loads at the accepting edge.
// Throughput: one pixel per clock; a stalled output only holds the full
// stages behind it, and any bubble ahead of a full stage is filled.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets grayscale
// mode, unmasked mix and strength 255.
`include "masked_grayscale_invert_blend_defines.svh"

module masked_grayscale_invert_blend
    import mgib_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mgib_cfg_if.sink  i_cfg,
    mgib_in_if.sink   i_in,
    mgib_out_if.source o_out
);

    t_cfg        cfg;
    logic [31:0] eff;

    logic        r_v1, r_v2, r_v3, r_v4;
    logic        rdy1, rdy2, rdy3, rdy4;

    logic [31:0] r_cur1, r_eff1;
    logic [15:0] r_msrc1;
    logic        r_umask1;
    logic [31:0] r_cur2, r_eff2;
    logic [7:0]  r_mix2;
    logic [15:0] r_prod3 [NumCh];
    logic [31:0] r_res4;

    logic [15:0] n_msrc;
    logic [7:0]  n_mix;
    logic [15:0] n_prod [NumCh];
    logic [31:0] n_res;

    mgib_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mgib_effect u_eff (
        .i_mode (cfg.filter_mode),
        .i_src  (i_in.source_pixel),
        .o_eff  (eff)
    );

    assign rdy4 = !r_v4 || o_out.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign i_in.ready        = rdy1;
    assign o_out.valid       = r_v4;
    assign o_out.result_pixel = r_res4;

    always_comb begin
        n_msrc = cfg.use_mask ? (16'(i_in.mask_level * cfg.strength) + {8'd0, MixRound})
                              : {8'd0, cfg.strength};
        n_mix  = r_umask1 ? div255(r_msrc1) : r_msrc1[7:0];
        for (int i = 0; i < NumCh; i++) begin
            n_prod[i] = 16'(r_cur2[i*8 +: 8] * (FullMix - r_mix2))
                      + 16'(r_eff2[i*8 +: 8] * r_mix2) + {8'd0, MixRound};
        end
        for (int i = 0; i < NumCh; i++) begin
            n_res[i*8 +: 8] = div255(r_prod3[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in.valid) begin
            r_cur1   <= i_in.current_pixel;
            r_eff1   <= eff;
            r_msrc1  <= n_msrc;
            r_umask1 <= cfg.use_mask;
        end
        if (rdy2 && r_v1) begin
            r_cur2 <= r_cur1;
            r_eff2 <= r_eff1;
            r_mix2 <= n_mix;
        end
        if (rdy3 && r_v2) begin
            r_prod3 <= n_prod;
        end
        if (rdy4 && r_v3) begin
            r_res4 <= n_res;
        end
    end

    `MGIB_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_in.valid && i_in.ready, r_v1)
    `MGIB_ASSERT_NEXT(a_s2_holds, i_clk, i_rst_n, r_v2 && !rdy3, r_v2 && $stable(r_mix2))
    `MGIB_ASSERT_NEXT(a_s3_holds, i_clk, i_rst_n, r_v3 && !rdy4, r_v3)
    `MGIB_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n, o_out.valid && o_out.ready && !r_v3,
                      !o_out.valid)

endmodule
